// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Field widths, action codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
	localparam int OperandWidth = 16;
	localparam int DenWidth     = OperandWidth - 1;
	localparam int ProdWidth    = 2 * OperandWidth;
	localparam int MagWidth     = ProdWidth;
	localparam int ResNumWidth  = 32;
	localparam int ResDenWidth  = 30;
	localparam int CntWidth     = $clog2(MagWidth + 1);

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_CMP = 3'd4
	} action_t;

	typedef struct packed {
		logic [2:0]                     action;
		logic signed [OperandWidth-1:0] a_num;
		logic [DenWidth-1:0]            a_den;
		logic signed [OperandWidth-1:0] b_num;
		logic [DenWidth-1:0]            b_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [ResNumWidth-1:0] res_num;
		logic [ResDenWidth-1:0]        res_den;
		logic                          less;
		logic                          equal;
		logic                          greater;
		logic                          div_by_zero;
	} rau_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_FORM,
		ST_GCD_LOAD,
		ST_GCD_DIV,
		ST_GCD_STEP,
		ST_RED_NUM,
		ST_RED_NUM_WAIT,
		ST_RED_DEN,
		ST_RED_DEN_WAIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic prod;
		logic form;
		logic gcd_load;
		logic div_start_gcd;
		logic gcd_step;
		logic div_start_num;
		logic take_num;
		logic div_start_den;
		logic take_den;
		logic finish;
	} rau_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic rem_zero;
		logic skip_reduce;
	} rau_sts_t;
endpackage
`default_nettype wire

// ===== hdl/rau_divider.sv =====
// ----------------------------------------------------------------------------
// rau_divider: restoring unsigned divider, one quotient bit per cycle
// Shared by the Euclid remainder steps and the two exact reductions.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_divider import rau_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [MagWidth-1:0] dividend,
	input  wire logic [MagWidth-1:0] divisor,
	output logic                     done,
	output logic [MagWidth-1:0]      quotient,
	output logic [MagWidth-1:0]      remainder
);
	logic [MagWidth-1:0] quo_q;
	logic [MagWidth-1:0] rem_q;
	logic [MagWidth-1:0] dsr_q;
	logic [CntWidth-1:0] cnt_q;
	logic                busy_q;
	logic [MagWidth:0]   trial;
	logic [MagWidth:0]   diff;

	assign trial = {rem_q, quo_q[MagWidth-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntWidth'(MagWidth);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntWidth'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[MagWidth]) begin
				rem_q <= diff[MagWidth-1:0];
				quo_q <= {quo_q[MagWidth-2:0], 1'b1};
			end else begin
				rem_q <= trial[MagWidth-1:0];
				quo_q <= {quo_q[MagWidth-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ===== hdl/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, cross products, gcd and reduction
// Executes controller commands; one multiplier and one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_datapath import rau_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rau_in_t  in_item,
	input  wire rau_cmd_t cmd,
	output rau_sts_t      sts,
	output rau_out_t      result
);
	logic [2:0]                   act_q;
	logic signed [OperandWidth:0] an_q, bn_q;
	logic [DenWidth-1:0]          ad_q, bd_q;
	logic [1:0]                   pcnt_q;
	logic signed [ProdWidth+1:0]  left_q, right_q;
	logic [ProdWidth-1:0]         dd_q, mm_q;
	logic [MagWidth-1:0]          n_q, d_q, x_q, y_q, rn_q;
	logic                         neg_q, dz_q, skip_q;
	logic                         lt_q, eq_q, gt_q;
	logic signed [OperandWidth:0] mul_a, mul_b;
	logic signed [ProdWidth+1:0]  mul_p;
	logic signed [ProdWidth+2:0]  sum;
	logic [MagWidth-1:0]          div_n, div_d, quo, rem;
	logic                         div_start, div_done;

	always_comb begin
		unique case (pcnt_q)
			2'd0:    begin mul_a = an_q; mul_b = $signed({2'b0, bd_q}); end
			2'd1:    begin mul_a = $signed({2'b0, ad_q}); mul_b = bn_q; end
			2'd2:    begin mul_a = $signed({2'b0, ad_q}); mul_b = $signed({2'b0, bd_q}); end
			default: begin
				mul_a = an_q[OperandWidth] ? -an_q : an_q;
				mul_b = bn_q[OperandWidth] ? -bn_q : bn_q;
			end
		endcase
	end
	assign mul_p = (ProdWidth+2)'(mul_a * mul_b);

	always_comb begin
		if (act_q == ACT_SUB) sum = (ProdWidth+3)'(left_q) - (ProdWidth+3)'(right_q);
		else                  sum = (ProdWidth+3)'(left_q) + (ProdWidth+3)'(right_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pcnt_q <= '0;
		else if (cmd.load) pcnt_q <= '0;
		else if (cmd.prod) pcnt_q <= pcnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_item.action;
			an_q  <= (OperandWidth+1)'(in_item.a_num);
			bn_q  <= (OperandWidth+1)'(in_item.b_num);
			ad_q  <= (in_item.a_den == '0) ? DenWidth'(1) : in_item.a_den;
			bd_q  <= (in_item.b_den == '0) ? DenWidth'(1) : in_item.b_den;
		end
		if (cmd.prod) begin
			unique case (pcnt_q)
				2'd0:    left_q  <= mul_p;
				2'd1:    right_q <= mul_p;
				2'd2:    dd_q    <= ProdWidth'(mul_p);
				default: mm_q    <= ProdWidth'(mul_p);
			endcase
		end
		if (cmd.form) begin
			lt_q <= 1'b0; eq_q <= 1'b0; gt_q <= 1'b0; dz_q <= 1'b0;
			skip_q <= 1'b1; neg_q <= 1'b0; n_q <= '0; d_q <= MagWidth'(1);
			unique case (act_q)
				ACT_ADD, ACT_SUB: begin
					neg_q  <= sum[ProdWidth+2];
					n_q    <= MagWidth'(sum[ProdWidth+2] ? -sum : sum);
					d_q    <= dd_q;
					skip_q <= 1'b0;
				end
				ACT_MUL: begin
					neg_q  <= an_q[OperandWidth] ^ bn_q[OperandWidth];
					n_q    <= mm_q;
					d_q    <= dd_q;
					skip_q <= 1'b0;
				end
				ACT_DIV: begin
					if (bn_q == '0) dz_q <= 1'b1;
					else begin
						neg_q  <= an_q[OperandWidth] ^ bn_q[OperandWidth];
						n_q    <= MagWidth'(left_q[ProdWidth+1] ? -left_q : left_q);
						d_q    <= MagWidth'(right_q[ProdWidth+1] ? -right_q : right_q);
						skip_q <= 1'b0;
					end
				end
				ACT_CMP: begin
					lt_q <= left_q < right_q;
					eq_q <= left_q == right_q;
					gt_q <= left_q > right_q;
				end
				default: ;
			endcase
		end
		if (cmd.gcd_load) begin
			x_q <= n_q;
			y_q <= d_q;
		end
		if (cmd.gcd_step) begin
			x_q <= y_q;
			y_q <= rem;
		end
		if (cmd.take_num) rn_q <= quo;
		if (cmd.take_den) begin
			if (rn_q == '0) begin
				n_q <= '0; d_q <= MagWidth'(1); neg_q <= 1'b0;
			end else begin
				n_q <= rn_q; d_q <= quo;
			end
		end
	end

	always_comb begin
		div_start = cmd.div_start_gcd | cmd.div_start_num | cmd.div_start_den;
		if (cmd.div_start_gcd) begin
			div_n = x_q; div_d = y_q;
		end else if (cmd.div_start_num) begin
			div_n = n_q; div_d = x_q;
		end else begin
			div_n = d_q; div_d = x_q;
		end
	end

	rau_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (quo),
		.remainder(rem)
	);

	assign sts.div_done    = div_done;
	assign sts.rem_zero    = (y_q == '0);
	assign sts.skip_reduce = skip_q;

	logic [MagWidth-1:0] sn;
	assign sn = neg_q ? -n_q : n_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.res_num     <= ResNumWidth'(sn);
			result.res_den     <= ResDenWidth'(d_q);
			result.less        <= lt_q;
			result.equal       <= eq_q;
			result.greater     <= gt_q;
			result.div_by_zero <= dz_q;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rau_controller.sv =====
// ----------------------------------------------------------------------------
// rau_controller: sequencer for the rational arithmetic unit
// Steps products, Euclid loop and reductions; raises busy and done.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_controller import rau_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire rau_sts_t sts,
	output rau_cmd_t      cmd,
	output logic          busy,
	output logic          done
);
	state_t state_q, state_d;
	logic [1:0] pcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pcnt_q  <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == ST_DONE);
			if (state_q == ST_PROD) pcnt_q <= pcnt_q + 1'b1;
			else                    pcnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:         if (start) state_d = ST_PROD;
			ST_PROD:         if (pcnt_q == 2'd3) state_d = ST_FORM;
			ST_FORM:         state_d = ST_GCD_LOAD;
			ST_GCD_LOAD:     state_d = ST_GCD_STEP;
			ST_GCD_STEP:     begin
				if (sts.skip_reduce) state_d = ST_DONE;
				else if (sts.rem_zero) state_d = ST_RED_NUM;
				else state_d = ST_GCD_DIV;
			end
			ST_GCD_DIV:      if (sts.div_done) state_d = ST_GCD_STEP;
			ST_RED_NUM:      state_d = ST_RED_NUM_WAIT;
			ST_RED_NUM_WAIT: if (sts.div_done) state_d = ST_RED_DEN;
			ST_RED_DEN:      state_d = ST_RED_DEN_WAIT;
			ST_RED_DEN_WAIT: if (sts.div_done) state_d = ST_DONE;
			ST_DONE:         state_d = ST_IDLE;
			default:         state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:     cmd.load = start;
			ST_PROD:     cmd.prod = 1'b1;
			ST_FORM:     cmd.form = 1'b1;
			ST_GCD_LOAD: cmd.gcd_load = 1'b1;
			ST_GCD_STEP: if (!sts.skip_reduce && !sts.rem_zero) cmd.div_start_gcd = 1'b1;
			ST_GCD_DIV:  cmd.gcd_step = sts.div_done;
			ST_RED_NUM:  cmd.div_start_num = 1'b1;
			ST_RED_NUM_WAIT: cmd.take_num = sts.div_done;
			ST_RED_DEN:  cmd.div_start_den = 1'b1;
			ST_RED_DEN_WAIT: cmd.take_den = sts.div_done;
			ST_DONE:     cmd.finish = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit: exact add, subtract, multiply, divide and compare
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the operand item on in_item and pulse start while busy is low;
//   the item is taken at that edge and busy rises. One result item appears
//   on result, marked by done, high for exactly one cycle; the receiver
//   cannot stall it, so capture it on that cycle.
// Sequence: the cross products are formed on the single multiplier, the
//   operands are formed and loaded, then the Euclid loop runs, each
//   remainder step being one division on the shared bit-serial divider,
//   then two exact divisions reduce the numerator and the denominator.
//   Compares, divide by zero and unused actions skip the Euclid loop and
//   the reductions. One item at a time; busy is low again in the cycle
//   that carries the result, so the next item may be taken there. The
//   divider sets the rate.
// Reset: arst_n clears the sequencer to idle at once; no result is pending
//   after reset and busy is low.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arith_unit import rau_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire rau_in_t in_item,
	output logic         busy,
	output logic         done,
	output rau_out_t     result
);
	rau_cmd_t cmd;
	rau_sts_t sts;

	// sequence the work
	rau_controller u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// hold operands and compute
	rau_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_item(in_item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	// a result strobe ends the item, so busy has dropped
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	// an accepted item always makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	// arithmetic results never carry a zero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.res_den != '0) else $error("zero denominator");
	// compare flags are exclusive
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({result.less, result.equal, result.greater}))
		else $error("flags clash");
endmodule
`default_nettype wire

// ===== sim/rational_arith_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit_tb: self-checking bench for the rational arithmetic unit
// Walks a directed table of operand items (extremes, every action, divide by
// zero, zero denominators, unused action codes), then random items. Each
// result item is compared field by field with its expected answer, typed into
// the table or computed by an independent exact-arithmetic predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arith_unit_tb;
	import rau_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int RandomItems   = 700;

	typedef struct {
		rau_in_t  item;
		bit       typed;   // expected result typed into the row
		rau_out_t res;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	rau_in_t  in_item = '0;
	logic     busy;
	logic     done;
	rau_out_t result;

	rau_out_t  answers_q[$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	stim_row_t rows[$];

	rational_arith_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.in_item (in_item),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic longint unsigned euclid(input longint unsigned x,
			input longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// Reduce |n|/d with sign, zero becomes 0/1.
	function automatic rau_out_t reduced(input bit neg, input longint unsigned n,
			input longint unsigned d);
		rau_out_t        r;
		longint unsigned g;
		longint signed   s;
		r = '0;
		g = euclid(n, d);
		if (g == 0) g = 1;
		n = n / g;
		d = d / g;
		if (n == 0) begin
			d = 1;
			neg = 1'b0;
		end
		s = neg ? -longint'(n) : longint'(n);
		r.res_num = s[31:0];
		r.res_den = d[29:0];
		return r;
	endfunction

	function automatic longint unsigned magnitude(input longint signed v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic rau_out_t rational_answer(input rau_in_t it);
		rau_out_t      r;
		longint signed an, ad, bn, bd, lhs, rhs, s;
		an = longint'(it.a_num);
		bn = longint'(it.b_num);
		ad = (it.a_den == 0) ? 1 : longint'({1'b0, it.a_den});
		bd = (it.b_den == 0) ? 1 : longint'({1'b0, it.b_den});
		lhs = an * bd;
		rhs = ad * bn;
		r = '0;
		r.res_den = 1;
		case (it.action)
			ACT_ADD: begin
				s = lhs + rhs;
				r = reduced(s < 0, magnitude(s), ad * bd);
			end
			ACT_SUB: begin
				s = lhs - rhs;
				r = reduced(s < 0, magnitude(s), ad * bd);
			end
			ACT_MUL: r = reduced((an < 0) != (bn < 0), magnitude(an) * magnitude(bn),
					ad * bd);
			ACT_DIV: begin
				if (bn == 0) r.div_by_zero = 1'b1;
				else r = reduced((an < 0) != (bn < 0), magnitude(lhs), magnitude(rhs));
			end
			ACT_CMP: begin
				r.less    = lhs < rhs;
				r.equal   = lhs == rhs;
				r.greater = lhs > rhs;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic rau_out_t flags_only(input bit lt, input bit eq, input bit gt,
			input bit dz);
		rau_out_t r;
		r = '0;
		r.res_den = 1;
		r.less = lt;
		r.equal = eq;
		r.greater = gt;
		r.div_by_zero = dz;
		return r;
	endfunction

	function automatic rau_in_t operands(input logic [2:0] act, input int an,
			input int ad, input int bn, input int bd);
		rau_in_t it;
		it.action = act;
		it.a_num  = an[15:0];
		it.a_den  = ad[14:0];
		it.b_num  = bn[15:0];
		it.b_den  = bd[14:0];
		return it;
	endfunction

	task automatic add_row(input rau_in_t it, input bit typed, input rau_out_t res);
		stim_row_t row;
		row.item = it;
		row.typed = typed;
		row.res = res;
		rows.push_back(row);
	endtask

	// Offer one item at the falling edge, hold start until it is taken.
	task automatic send_item(input rau_in_t it, input rau_out_t answer);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		answers_q.push_back(answer);
		@(negedge clk);
	endtask

	// Check every result item against the oldest expectation.
	always @(posedge clk) begin
		rau_out_t want;
		if (arst_n && done) begin
			if (answers_q.size() == 0) begin
				report_mismatch("result item with nothing expected");
			end else begin
				want = answers_q.pop_front();
				if (result.res_num !== want.res_num)
					report_mismatch($sformatf("res_num %0d, want %0d",
						result.res_num, want.res_num));
				if (result.res_den !== want.res_den)
					report_mismatch($sformatf("res_den %0d, want %0d",
						result.res_den, want.res_den));
				if (result.less !== want.less) report_mismatch("less flag");
				if (result.equal !== want.equal) report_mismatch("equal flag");
				if (result.greater !== want.greater) report_mismatch("greater flag");
				if (result.div_by_zero !== want.div_by_zero)
					report_mismatch("div_by_zero flag");
			end
		end
	end

	// Watchdog: count cycles with no item taken and no result seen.
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int random_num();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return int'($urandom_range(0, 20)) - 10;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic int random_den();
		case ($urandom_range(0, 5))
			0: return 32767;
			1: return 1;
			2: return 0;
			3: return $urandom_range(1, 12);
			default: return $urandom_range(0, 32767);
		endcase
	endfunction

	initial begin
		rau_in_t it;
		logic [2:0] act;
		int wait_cycles;

		// the first rows have their results typed in; the rest go through the predictor
		add_row(operands(ACT_DIV, 5, 3, 0, 7), 1, flags_only(0, 0, 0, 1));
		add_row(operands(ACT_DIV, -32768, 1, 0, 32767), 1, flags_only(0, 0, 0, 1));
		add_row(operands(ACT_CMP, 1, 2, 2, 4), 1, flags_only(0, 1, 0, 0));
		add_row(operands(ACT_CMP, -32768, 1, 32767, 1), 1, flags_only(1, 0, 0, 0));
		add_row(operands(ACT_CMP, 32767, 1, -32768, 1), 1, flags_only(0, 0, 1, 0));
		add_row(operands(ACT_SUB, 7, 3, 7, 3), 1, flags_only(0, 0, 0, 0));
		add_row(operands(3'd5, 9, 2, 4, 3), 1, flags_only(0, 0, 0, 0));
		add_row(operands(3'd6, -1, 0, -1, 0), 1, flags_only(0, 0, 0, 0));
		add_row(operands(3'd7, 32767, 32767, -32768, 32767), 1, flags_only(0, 0, 0, 0));
		add_row(operands(ACT_ADD, 1, 2, 1, 3), 0, '0);
		add_row(operands(ACT_ADD, -32768, 1, -32768, 1), 0, '0);
		add_row(operands(ACT_ADD, 32767, 32767, 32767, 32766), 0, '0);
		add_row(operands(ACT_SUB, -32768, 32767, 32767, 1), 0, '0);
		add_row(operands(ACT_MUL, -32768, 1, -32768, 1), 0, '0);
		add_row(operands(ACT_MUL, 32767, 32766, -32768, 32767), 0, '0);
		add_row(operands(ACT_MUL, 0, 5, -7, 3), 0, '0);
		add_row(operands(ACT_DIV, -32768, 1, 1, 32767), 0, '0);
		add_row(operands(ACT_DIV, 32767, 32767, -32768, 1), 0, '0);
		add_row(operands(ACT_DIV, 6, 4, -9, 6), 0, '0);
		add_row(operands(ACT_ADD, 3, 0, 5, 0), 0, '0);  // zero denominators read as 1
		add_row(operands(ACT_CMP, 4, 0, 8, 2), 0, '0);
		add_row(operands(ACT_CMP, -1, 32767, 0, 0), 0, '0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_item(rows[i].item,
				rows[i].typed ? rows[i].res : rational_answer(rows[i].item));

		// random part, mostly valid actions, a few unused codes
		repeat (RandomItems) begin
			act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			it = operands(act, random_num(), random_den(), random_num(), random_den());
			if ($urandom_range(0, 3) == 0)
				it = rau_in_t'({$urandom, $urandom, 1'($urandom)});
			send_item(it, rational_answer(it));
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (answers_q.size() != 0 && wait_cycles < WatchdogLimit) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (answers_q.size() != 0) report_mismatch("expected result items left over");
		if (mismatch_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/rau_pkg.sv
hdl/rau_divider.sv
hdl/rau_datapath.sv
hdl/rau_controller.sv
hdl/rational_arith_unit.sv
sim/rational_arith_unit_tb.sv
